/* src/trpad_pkg.sv */
// Shared types, constants and the firing-delay function for the triac
// phase-angle dimmer. No dependencies; used by every module in src.
package trpad_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned CH_MAX       = 8;
  localparam int unsigned CYCLE_W      = 20;
  localparam int unsigned PULSE_W      = 16;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CYCLE_W-1:0] CYCLE_RESET  = CYCLE_W'(16667);
  localparam logic [PULSE_W-1:0] PULSE_RESET  = PULSE_W'(8);
  localparam logic [CYCLE_W-1:0] ELAPSED_MAX  = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN    = LEVEL_W'(26);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(229);
  localparam int unsigned        SCALE_SHIFT  = 8;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ZC    = 2'd1,
    KIND_LEVEL = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE = 1'b0,
    REG_PULSE = 1'b1
  } cfg_reg_t;

  // Per-transaction control broadcast to every channel lane
  typedef struct packed {
    logic               tick;
    logic               zc;
    logic               set_lvl;
    logic [LEVEL_W-1:0] level;
    logic               cyc_we;
    logic [CYCLE_W-1:0] cyc_val;
    logic [CYCLE_W-1:0] cycle_ticks;
    logic [CYCLE_W-1:0] elapsed;
    logic [PULSE_W-1:0] pulse_ticks;
  } lane_ctl_t;

  typedef struct packed {
    logic gate;
    logic fired;
  } lane_sts_t;

  // delay = (cycle * (256 - clamp(level))) >> 8
  function automatic logic [CYCLE_W-1:0] delay_of(input logic [CYCLE_W-1:0] cycle,
                                                  input logic [LEVEL_W-1:0] raw);
    logic [LEVEL_W-1:0]         lv;
    logic [LEVEL_W-1:0]         factor;
    logic [CYCLE_W+LEVEL_W-1:0] prod;
    lv = raw;
    if (lv < LEVEL_MIN) lv = LEVEL_MIN;
    if (lv > LEVEL_MAX) lv = LEVEL_MAX;
    factor = LEVEL_W'(9'd256 - {1'b0, lv});
    prod = (CYCLE_W+LEVEL_W)'(cycle) * (CYCLE_W+LEVEL_W)'(factor);
    return prod[CYCLE_W+SCALE_SHIFT-1:SCALE_SHIFT];
  endfunction

endpackage

/* src/triac_phase_angle_dimmer_unit.sv */
// Top level of the triac phase-angle dimmer: input register, elapsed-tick
// counter, config registers, channel lanes and result register.
// Depends on trpad_pkg and trpad_lane.
//
//   port group | direction | handshake         | carries
//   in_*       | input     | in_valid/in_ready | kind, channel, level
//   out_*      | output    | out_valid/out_ready | gate_mask, fired_mask
//   cfg_*      | input     | cfg_we            | cfg_idx, cfg_wdata
//
// One transaction per clock sustained while out_ready stays high; each
// result passes the input register, then the result register.
// The per-channel delay multiply sits behind level and cycle writes, so a
// tick is a counter increment plus parallel compares. Synchronous
// active-low reset clears all but the payload registers and loads the
// default cycle and pulse lengths. A stalled result holds the pipe;
// in_ready drops only when both registers are full and out_ready is low.
module triac_phase_angle_dimmer_unit #(
  parameter int unsigned CHANNELS = trpad_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [trpad_pkg::CHAN_W-1:0]      in_channel,
  input  logic [trpad_pkg::LEVEL_W-1:0]     in_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [trpad_pkg::CH_MAX-1:0]      out_gate_mask,
  output logic [trpad_pkg::CH_MAX-1:0]      out_fired_mask,
  input  logic                              cfg_we,
  input  logic [trpad_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [trpad_pkg::CYCLE_W-1:0]     cfg_wdata
);

  logic                              s1_valid_r;
  logic [1:0]                        s1_kind_r;
  logic [trpad_pkg::CHAN_W-1:0]      s1_chan_r;
  logic [trpad_pkg::LEVEL_W-1:0]     s1_level_r;
  logic                              out_valid_r;
  logic [trpad_pkg::CH_MAX-1:0]      gate_r, gate_nxt;
  logic [trpad_pkg::CH_MAX-1:0]      fired_r, fired_nxt;
  logic [trpad_pkg::CYCLE_W-1:0]     cycle_r;
  logic [trpad_pkg::PULSE_W-1:0]     pulse_r;
  logic [trpad_pkg::CYCLE_W-1:0]     elapsed_r, elapsed_nxt;
  logic                              adv;
  logic                              is_tick, is_zc, is_lvl;
  trpad_pkg::lane_ctl_t              ctl;
  trpad_pkg::lane_sts_t              sts_w [CHANNELS];

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    is_tick = 1'b0;
    is_zc   = 1'b0;
    is_lvl  = 1'b0;
    case (s1_kind_r)
      trpad_pkg::KIND_TICK:  is_tick = 1'b1;
      trpad_pkg::KIND_ZC:    is_zc   = 1'b1;
      trpad_pkg::KIND_LEVEL: is_lvl  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (adv && is_tick && (elapsed_r != trpad_pkg::ELAPSED_MAX))
      elapsed_nxt = elapsed_r + 1'b1;
    if (adv && is_zc) elapsed_nxt = '0;
  end

  always_comb begin
    ctl.tick        = is_tick;
    ctl.zc          = is_zc;
    ctl.set_lvl     = is_lvl;
    ctl.level       = s1_level_r;
    ctl.cyc_we      = cfg_we && (cfg_idx == trpad_pkg::REG_CYCLE);
    ctl.cyc_val     = cfg_wdata;
    ctl.cycle_ticks = cycle_r;
    ctl.elapsed     = elapsed_nxt;
    ctl.pulse_ticks = pulse_r;
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    trpad_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .sel   (s1_chan_r == trpad_pkg::CHAN_W'(i)),
      .ctl   (ctl),
      .sts   (sts_w[i])
    );
  end

  always_comb begin
    gate_nxt  = '0;
    fired_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      gate_nxt[i]  = sts_w[i].gate;
      fired_nxt[i] = sts_w[i].fired;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cycle_r     <= trpad_pkg::CYCLE_RESET;
      pulse_r     <= trpad_pkg::PULSE_RESET;
      elapsed_r   <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      if (in_ready) s1_valid_r <= in_valid;
      if (!out_valid_r || out_ready) out_valid_r <= s1_valid_r;
      if (cfg_we) begin
        case (cfg_idx)
          trpad_pkg::REG_CYCLE: cycle_r <= cfg_wdata;
          trpad_pkg::REG_PULSE: pulse_r <= cfg_wdata[trpad_pkg::PULSE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: hold unless the stage advances
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind_r  <= in_kind;
      s1_chan_r  <= in_channel;
      s1_level_r <= in_level;
    end
    if (adv) begin
      gate_r  <= gate_nxt;
      fired_r <= fired_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gate_mask  = gate_r;
  assign out_fired_mask = fired_r;

endmodule

/* src/trpad_lane.sv */
// One dimmer channel: stored level, precomputed firing delay, fired flag
// and gate pulse countdown. Depends on trpad_pkg.
module trpad_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  sel,
  input  trpad_pkg::lane_ctl_t  ctl,
  output trpad_pkg::lane_sts_t  sts
);

  logic [trpad_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [trpad_pkg::CYCLE_W-1:0] delay_r, delay_nxt;
  logic                          fired_r, fired_nxt;
  logic [trpad_pkg::PULSE_W-1:0] pulse_r, pulse_nxt;

  always_comb begin
    level_nxt = level_r;
    delay_nxt = delay_r;
    fired_nxt = fired_r;
    pulse_nxt = pulse_r;
    if (adv) begin
      if (ctl.tick) begin
        if (pulse_r != '0) pulse_nxt = pulse_r - 1'b1;
        if (!fired_r && (ctl.elapsed >= delay_r)) begin
          fired_nxt = 1'b1;
          pulse_nxt = ctl.pulse_ticks;
        end
      end
      if (ctl.zc) fired_nxt = 1'b0;
      if (ctl.set_lvl && sel) begin
        level_nxt = ctl.level;
        delay_nxt = trpad_pkg::delay_of(ctl.cycle_ticks, ctl.level);
      end
    end
    // rescale on cycle write; user must do it only while idle; unchecked
    if (ctl.cyc_we) delay_nxt = trpad_pkg::delay_of(ctl.cyc_val, level_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      delay_r <= trpad_pkg::delay_of(trpad_pkg::CYCLE_RESET, '0);
      fired_r <= 1'b0;
      pulse_r <= '0;
    end else begin
      level_r <= level_nxt;
      delay_r <= delay_nxt;
      fired_r <= fired_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  assign sts.gate  = (pulse_nxt != '0);
  assign sts.fired = fired_nxt;

endmodule

/* test/triac_phase_angle_dimmer_unit_tb.sv */
// Self-checking testbench for triac_phase_angle_dimmer_unit: random and directed
// tick, zero-crossing and level transactions, checked against an in-bench predictor.
// Depends on trpad_pkg and the dimmer RTL in src.
module triac_phase_angle_dimmer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trpad_pkg::*;

  localparam logic [1:0]         KIND_SPARE     = 2'd3;
  localparam int unsigned        LVL_FLOOR      = 26;
  localparam int unsigned        LVL_CEIL       = 229;
  localparam int unsigned        FULL_SCALE     = 256;
  localparam int unsigned        SCALE_BITS     = 8;
  localparam logic [CYCLE_W-1:0] TICK_SAT       = '1;
  localparam int                 LONG_HOLD      = 60;
  localparam int                 WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } dimmer_event_t;

  typedef struct packed {
    logic [CH_MAX-1:0] gate;
    logic [CH_MAX-1:0] fired;
  } dimmer_masks_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_kind = KIND_TICK;
  logic [CHAN_W-1:0]    in_channel = '0;
  logic [LEVEL_W-1:0]   in_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_MAX-1:0]    out_gate_mask;
  logic [CH_MAX-1:0]    out_fired_mask;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_CYCLE;
  logic [CYCLE_W-1:0]   cfg_wdata = '0;

  // predictor state
  logic [CYCLE_W-1:0] model_cycle = CYCLE_W'(16667);
  logic [PULSE_W-1:0] model_pulse = PULSE_W'(8);
  logic [CYCLE_W-1:0] tick_count = '0;
  logic [CH_MAX-1:0]  has_fired = '0;
  logic [LEVEL_W-1:0] chan_level [CH_MAX];
  logic [PULSE_W-1:0] gate_left [CH_MAX];

  dimmer_event_t pending_events [$];
  dimmer_masks_t expected_masks [$];
  dimmer_event_t next_event;
  dimmer_masks_t predicted;
  dimmer_masks_t oldest;

  logic [LEVEL_W-1:0] corner_levels [8] = '{8'd0, 8'd255, 8'd26, 8'd229,
                                            8'd25, 8'd230, 8'd128, 8'd27};

  int  error_count = 0;
  int  pushed_total = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  quiet = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  idle_cycles = 0;

  triac_phase_angle_dimmer_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_channel     (in_channel),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_gate_mask  (out_gate_mask),
    .out_fired_mask (out_fired_mask),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [CYCLE_W-1:0] firing_delay_of(input logic [LEVEL_W-1:0] raw);
    int unsigned lv;
    logic [35:0] prod;
    lv = raw;
    if (lv < LVL_FLOOR) lv = LVL_FLOOR;
    if (lv > LVL_CEIL) lv = LVL_CEIL;
    prod = 36'(model_cycle) * 36'(FULL_SCALE - lv);
    return CYCLE_W'(prod >> SCALE_BITS);
  endfunction

  function automatic dimmer_masks_t apply_dimmer_event(input dimmer_event_t ev);
    dimmer_masks_t m;
    m = '0;
    case (ev.kind)
      KIND_TICK: begin
        if (tick_count != TICK_SAT) tick_count = tick_count + 1'b1;
        for (int i = 0; i < CH_MAX; i++) begin
          if (gate_left[i] != 0) gate_left[i] = gate_left[i] - 1'b1;
          if (!has_fired[i] && tick_count >= firing_delay_of(chan_level[i])) begin
            has_fired[i] = 1'b1;
            gate_left[i] = model_pulse;
          end
        end
      end
      KIND_ZC: begin
        tick_count = '0;
        has_fired = '0;
      end
      KIND_LEVEL: chan_level[ev.channel] = ev.level;
      KIND_SPARE: ;
    endcase
    for (int i = 0; i < CH_MAX; i++) begin
      m.gate[i] = (gate_left[i] != 0);
    end
    m.fired = has_fired;
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns ERROR %s", $time, msg);
    error_count++;
  endtask

  // input side: predict on accept, then offer the next queued transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = apply_dimmer_event('{kind: in_kind, channel: in_channel,
                                         level: in_level});
        expected_masks.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          next_event = pending_events.pop_front();
          in_kind <= next_event.kind;
          in_channel <= next_event.channel;
          in_level <= next_event.level;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure, with long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_masks.size() == 0) begin
        report_mismatch($sformatf("result gate=%h fired=%h with no transaction pending",
                                  out_gate_mask, out_fired_mask));
      end else begin
        oldest = expected_masks.pop_front();
        if (out_gate_mask !== oldest.gate)
          report_mismatch($sformatf("gate_mask got %h want %h", out_gate_mask, oldest.gate));
        if (out_fired_mask !== oldest.fired)
          report_mismatch($sformatf("fired_mask got %h want %h", out_fired_mask,
                                    oldest.fired));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_event(input logic [1:0] kind, input int ch, input int lvl);
    pending_events.push_back('{kind: kind, channel: CHAN_W'(ch), level: LEVEL_W'(lvl)});
    pushed_total++;
  endtask

  function automatic int pick_level();
    if ($urandom_range(0, 1)) return corner_levels[$urandom_range(0, 7)];
    return $urandom_range(0, 255);
  endfunction

  // optional zero crossing, then a run of ticks with level writes and spare codes mixed in
  task automatic push_half_cycle(input int ticks, input bit with_zc);
    int roll;
    if (with_zc) push_event(KIND_ZC, $urandom_range(0, 7), $urandom_range(0, 255));
    repeat (ticks) begin
      roll = $urandom_range(0, 99);
      if (roll < 9) push_event(KIND_LEVEL, $urandom_range(0, 7), pick_level());
      else if (roll < 12) push_event(KIND_SPARE, $urandom_range(0, 7), $urandom_range(0, 255));
      else push_event(KIND_TICK, $urandom_range(0, 7), $urandom_range(0, 255));
    end
  endtask

  // wait until the pipe is drained, then wait out the extra hold the caller asks for
  task automatic settle(input int extra);
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_masks.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CYCLE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_CYCLE) model_cycle = val;
    else model_pulse = val[PULSE_W-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CYCLE_W-1:0] cyc, input logic [CYCLE_W-1:0] pulse);
    write_reg(REG_CYCLE, cyc);
    write_reg(REG_PULSE, pulse);
    settle(4);
  endtask

  task automatic fill_half_cycles(input int n_items);
    int target;
    int lo;
    int hi;
    int ticks;
    target = pushed_total + n_items;
    while (pushed_total < target) begin
      lo = model_cycle / 4;
      hi = model_cycle + model_cycle / 4 + 4;
      if (lo > 100) lo = 100;
      if (hi > 120) hi = 120;
      ticks = $urandom_range(lo, hi);
      // trim the last half cycle to the requested count
      if (ticks > target - pushed_total) ticks = target - pushed_total;
      push_half_cycle(ticks, $urandom_range(0, 99) < 88);
    end
  endtask

  task automatic run_phase(input logic [CYCLE_W-1:0] cyc, input logic [CYCLE_W-1:0] pulse,
                           input int n_items, input int tx_pct, input int rx_pct);
    configure(cyc, pulse);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    fill_half_cycles(n_items);
    settle(8);
  endtask

  initial begin
    for (int i = 0; i < CH_MAX; i++) begin
      chan_level[i] = '0;
      gate_left[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settle(2);

    // reset defaults: nothing can fire within a few ticks
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    for (int ch = 0; ch < CH_MAX; ch++) push_event(KIND_LEVEL, ch, corner_levels[ch]);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_TICK, 7, 255);
    push_event(KIND_ZC, 5, 170);
    push_event(KIND_SPARE, 7, 255);
    settle(8);

    // zero cycle and zero pulse: fire on the first tick, gate never driven
    configure('0, '0);
    push_event(KIND_ZC, 0, 0);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_TICK, 2, 85);
    push_event(KIND_SPARE, 0, 0);
    push_event(KIND_ZC, 4, 42);
    push_event(KIND_TICK, 1, 1);
    settle(8);

    // one-tick cycle and pulse
    configure(CYCLE_W'(1), CYCLE_W'(1));
    push_event(KIND_ZC, 0, 0);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_LEVEL, 3, 0);
    push_event(KIND_ZC, 0, 0);
    push_event(KIND_TICK, 6, 200);
    push_event(KIND_TICK, 0, 0);
    settle(8);

    run_phase(CYCLE_W'(48), CYCLE_W'(4), 80, 30, 30);

    // fill the pipe behind a long receiver hold, then drain before going on
    configure(CYCLE_W'(40), CYCLE_W'(20));
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    hold_requests++;
    fill_half_cycles(40);
    settle(0);
    fill_half_cycles(40);
    settle(8);

    run_phase(TICK_SAT, CYCLE_W'(16'hFFFF), 30, 20, 20);
    run_phase(CYCLE_W'(24), '0, 50, 0, 0);
    run_phase(CYCLE_W'($urandom_range(16, 96)), CYCLE_W'($urandom_range(1, 30)), 80, 40, 10);
    // upper write bits must not reach the pulse length
    run_phase(CYCLE_W'(64), CYCLE_W'(20'hA0003), 70, 10, 40);

    quiet = 1'b1;
    run_phase(CYCLE_W'(32), CYCLE_W'(2), 60, 0, 0);

    settle(12);
    if (error_count == 0 && expected_masks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
